[sv/cgmc_pkg.sv]
// Shared constants and types for the channel gain median calibrator.
// No dependencies; imported by cgmc_div and channel_gain_median_calibrator.
package cgmc_pkg;

	localparam int CH_W     = 10;
	localparam int NPE_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int LF_W     = 16;
	localparam int SPU_W    = 8;
	localparam int CHANNELS = 1024;
	localparam int SAMPLES  = 128;
	localparam int IDX_W    = 7;
	localparam int CNT_W    = 8;
	localparam int DIVD_W   = LF_W + 20;
	localparam int QCNT_W   = 6;
	localparam int META_W   = CNT_W + GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4501;
	localparam logic [SPU_W-1:0]  SPU_RESET  = 8'd100;
	localparam logic [LF_W-1:0]   LF_RESET   = 16'd6554;

	localparam logic REG_SPU = 1'b0;
	localparam logic REG_LF  = 1'b1;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [NPE_W-1:0]  npe_t;
	typedef logic [GAIN_W-1:0] gain_t;

endpackage

[sv/cgmc_div.sv]
// Restoring divider, one quotient bit per cycle: (learning factor << 20) / median.
// Depends on cgmc_pkg.
module cgmc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cgmc_pkg::DIVD_W-1:0]   dividend,
	input  logic [cgmc_pkg::NPE_W-1:0]    divisor,
	output logic                          done,
	output logic [cgmc_pkg::DIVD_W-1:0]   quotient
);
	import cgmc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [NPE_W-1:0]  rem_q;
	logic [NPE_W-1:0]  dsr_q;
	logic [DIVD_W-1:0] quo_q;
	logic [NPE_W:0]    trial;
	logic [NPE_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				else cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NPE_W-1:0] : trial[NPE_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/channel_gain_median_calibrator.sv]
// Per-channel gain calibrator: sample batches, bitwise median select, smoothed factor.
// Depends on cgmc_pkg and cgmc_div.
//
// Usage:
//   s_axis carries one hit per transfer (channel, amplitude). m_axis returns one
//   result per hit. cfg_we/cfg_index/cfg_data write the batch size (index 0) and
//   the learning factor (index 1); write only while no hit is in flight.
//   A hit that does not complete a batch passes from the table update
//   straight to the output stage. A hit that completes a batch of n samples
//   takes more steps: the median is found bit by bit, 16 passes over the
//   channel's samples through the single read port of the sample memory, then
//   the divider produces the inverse median. One hit is handled at a time;
//   s_axis_tready is low while it is worked on. After reset the block sweeps
//   its 1024-entry per-channel table (fill counts and factors) and takes no
//   hit meanwhile; config writes are taken at once. The result register holds
//   while m_axis_tready is low; the block then accepts and works on the next
//   hit, and stalls only when a second result is ready.
module channel_gain_median_calibrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [9:0] channel, [25:10] sample_npe
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [9:0] out_channel, [25:10] median_npe,
	                                    // [41:26] calibration_factor
	output logic [1:0]  m_axis_tuser,   // [0] accepted, [1] updated
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import cgmc_pkg::*;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_META = 4'd2;
	localparam logic [3:0] ST_SCAN = 4'd3;
	localparam logic [3:0] ST_DEC  = 4'd4;
	localparam logic [3:0] ST_MED  = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_SUM  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]       state_q;
	logic [CH_W-1:0]  clr_q;
	logic [SPU_W-1:0] spu_q;
	logic [LF_W-1:0]  lf_q;

	chan_t ch_q;
	npe_t  npe_q;
	gain_t gain_q;

	// per-channel table: fill count over factor
	logic [META_W-1:0] meta_mem [CHANNELS];
	logic [META_W-1:0] meta_rdata;
	logic              meta_we;
	chan_t             meta_waddr;
	logic [META_W-1:0] meta_wdata;

	logic [NPE_W-1:0] sample_mem [CHANNELS*SAMPLES];
	logic [NPE_W-1:0] sample_rdata;
	logic             sample_we;

	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] ptr_q;
	logic             vld_s1;
	logic [3:0]       bit_q;
	logic [NPE_W-1:0] pa_q, pb_q;
	logic [IDX_W-1:0] ka_q, kb_q;
	logic [CNT_W-1:0] ca_q, cb_q;
	npe_t             med_q;
	logic [32:0]      prod_q;

	logic             res_acc_q, res_upd_q;
	npe_t             res_med_q;
	gain_t            res_fac_q;

	logic             out_valid_q;
	chan_t            out_ch_q;
	logic             out_acc_q, out_upd_q;
	npe_t             out_med_q;
	gain_t            out_fac_q;

	logic [IDX_W-1:0] cnt;
	logic [CNT_W-1:0] cnt1;
	logic [CNT_W-1:0] limit;
	logic [NPE_W-1:0] hi_mask;
	logic             match_a, match_b;
	logic [NPE_W:0]   med_sum;
	npe_t             med;
	logic             div_done;
	logic [DIVD_W-1:0] quo;
	logic [36:0]      total;
	gain_t            new_fac;
	logic             s_fire;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (meta_rdata[GAIN_W+CNT_W-1]) cnt = {IDX_W{1'b1}};
		else cnt = meta_rdata[GAIN_W +: IDX_W];
		cnt1 = {1'b0, cnt} + 1'b1;
		if (spu_q == '0) limit = CNT_W'(1);
		else if (spu_q > CNT_W'(SAMPLES)) limit = CNT_W'(SAMPLES);
		else limit = spu_q;
	end

	assign hi_mask = 16'hFFFE << bit_q;
	assign match_a = (((sample_rdata ^ pa_q) & hi_mask) == '0) && !sample_rdata[bit_q];
	assign match_b = (((sample_rdata ^ pb_q) & hi_mask) == '0) && !sample_rdata[bit_q];

	assign med_sum = {1'b0, pa_q} + {1'b0, pb_q};
	assign med     = med_sum[NPE_W:1];

	assign total   = {4'b0, prod_q} + {1'b0, quo} + 37'd32768;
	assign new_fac = (|total[36:32]) ? {GAIN_W{1'b1}} : total[31:16];

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = ch_q;
		meta_wdata = {{CNT_W{1'b0}}, GAIN_RESET};
		case (state_q)
			ST_CLR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
			end
			ST_META: begin
				meta_we    = (npe_q != '0) && (cnt1 < limit);
				meta_wdata = {cnt1, meta_rdata[GAIN_W-1:0]};
			end
			ST_SUM: begin
				meta_we    = 1'b1;
				meta_wdata = {{CNT_W{1'b0}}, new_fac};
			end
			default: meta_we = 1'b0;
		endcase
	end

	assign sample_we = (state_q == ST_META) && (npe_q != '0);

	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
		meta_rdata <= meta_mem[s_axis_tdata[CH_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sample_we) sample_mem[{ch_q, cnt}] <= npe_q;
		sample_rdata <= sample_mem[{ch_q, ptr_q[IDX_W-1:0]}];
	end

	cgmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MED),
		.dividend ({lf_q, 20'b0}),
		.divisor  ((med == '0) ? NPE_W'(1) : med),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			spu_q       <= SPU_RESET;
			lf_q        <= LF_RESET;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SPU) spu_q <= cfg_data[SPU_W-1:0];
				else lf_q <= cfg_data;
			end
			vld_s1 <= (state_q == ST_SCAN) && (ptr_q < n_q);
			if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {CH_W{1'b1}}) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_fire) state_q <= ST_META;
				ST_META: begin
					if (npe_q != '0 && cnt1 >= limit) state_q <= ST_SCAN;
					else state_q <= ST_OUT;
				end
				ST_SCAN: if (ptr_q == n_q) state_q <= ST_DEC;
				ST_DEC: begin
					if (bit_q == '0) state_q <= ST_MED;
					else state_q <= ST_SCAN;
				end
				ST_MED: state_q <= ST_DIV;
				ST_DIV: if (div_done) state_q <= ST_SUM;
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, steered by the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q  <= s_axis_tdata[CH_W-1:0];
				npe_q <= s_axis_tdata[CH_W +: NPE_W];
			end
			ST_META: begin
				gain_q    <= meta_rdata[GAIN_W-1:0];
				res_fac_q <= meta_rdata[GAIN_W-1:0];
				res_acc_q <= (npe_q != '0);
				res_upd_q <= 1'b0;
				res_med_q <= '0;
				n_q       <= cnt1;
				ptr_q     <= '0;
				bit_q     <= 4'd15;
				pa_q      <= '0;
				pb_q      <= '0;
				ca_q      <= '0;
				cb_q      <= '0;
				kb_q      <= cnt1[IDX_W:1];
				ka_q      <= cnt1[0] ? cnt1[IDX_W:1] : cnt1[IDX_W:1] - 1'b1;
			end
			ST_SCAN: begin
				ptr_q <= ptr_q + 1'b1;
				if (vld_s1 && match_a) ca_q <= ca_q + 1'b1;
				if (vld_s1 && match_b) cb_q <= cb_q + 1'b1;
			end
			ST_DEC: begin
				// rank falls beyond the zero-bit group: take bit one, skip that group
				if ({1'b0, ka_q} >= ca_q) begin
					pa_q[bit_q] <= 1'b1;
					ka_q        <= ka_q - ca_q[IDX_W-1:0];
				end
				if ({1'b0, kb_q} >= cb_q) begin
					pb_q[bit_q] <= 1'b1;
					kb_q        <= kb_q - cb_q[IDX_W-1:0];
				end
				ca_q  <= '0;
				cb_q  <= '0;
				ptr_q <= '0;
				if (bit_q != '0) bit_q <= bit_q - 1'b1;
			end
			ST_MED: begin
				med_q  <= med;
				prod_q <= gain_q * (17'h10000 - {1'b0, lf_q});
			end
			ST_SUM: begin
				res_upd_q <= 1'b1;
				res_med_q <= med_q;
				res_fac_q <= new_fac;
			end
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_ch_q  <= ch_q;
					out_acc_q <= res_acc_q;
					out_upd_q <= res_upd_q;
					out_med_q <= res_med_q;
					out_fac_q <= res_fac_q;
				end
			end
			default: ptr_q <= ptr_q;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_fac_q, out_med_q, out_ch_q};
	assign m_axis_tuser  = {out_upd_q, out_acc_q};

endmodule
